### hdl/yay0_lz_decompressor_defines.svh
// ----------------------------------------------------------------------------
// yay0_lz_decompressor_defines.svh
// Assertion macros shared by the decompressor RTL. They sample on clk_i and
// are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef YAY0_LZ_DECOMPRESSOR_DEFINES_SVH
`define YAY0_LZ_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define YAY0_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define YAY0_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/yay0_pkg.sv
// ----------------------------------------------------------------------------
// yay0_pkg
// Types and constants of the Yay0 LZ token decompressor.
// ----------------------------------------------------------------------------
package yay0_pkg;

  localparam int unsigned WINDOW_SIZE = 4096;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned DIST_W      = 13;   // distance 1..4096
  localparam int unsigned LEN_W       = 9;    // run length 1..273
  localparam int unsigned CNT_W       = 24;
  localparam logic [CNT_W-1:0] CNT_MAX = 24'hffffff;
  localparam int unsigned SHORT_BIAS  = 2;
  localparam int unsigned LONG_BIAS   = 18;
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QPTR_W      = 1;

  // Raw token as it arrives on the input channel.
  typedef struct packed {
    logic        is_literal;
    logic [7:0]  literal_byte;
    logic [15:0] link_word;
    logic [7:0]  count_extra;
  } tok_in_t;

  // Classified token held in the queue.
  typedef struct packed {
    logic              is_literal;
    logic [7:0]        literal_byte;
    logic [DIST_W-1:0] distance;
    logic [LEN_W-1:0]  len;
  } tok_t;

  // One output group.
  typedef struct packed {
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [7:0] out_byte4;
    logic [7:0] out_byte5;
    logic [7:0] out_byte6;
    logic [7:0] out_byte7;
    logic [3:0] byte_count;
    logic       last_of_run;
    logic       stream_done;
    logic       bad_reference;
  } grp_t;

  typedef struct packed {
    logic [CNT_W-1:0] decoded_size;
  } cfg_t;

endpackage

### hdl/yay0_ifs.sv
// ----------------------------------------------------------------------------
// yay0_ifs
// Valid/ready channel interfaces for tokens, output groups and configuration.
// ----------------------------------------------------------------------------
interface yay0_tok_if import yay0_pkg::*; ();
  logic    valid;
  logic    ready;
  tok_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface yay0_grp_if import yay0_pkg::*; ();
  logic valid;
  logic ready;
  grp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface yay0_cfg_if import yay0_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/yay0_ram.sv
// ----------------------------------------------------------------------------
// yay0_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module yay0_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### hdl/yay0_front.sv
// ----------------------------------------------------------------------------
// yay0_front
// Token intake: decode a raw token into literal byte, distance and run length.
// ----------------------------------------------------------------------------
module yay0_front import yay0_pkg::*; (
  yay0_tok_if.sink tok_i,
  output logic     push_valid_o,
  output tok_t     push_data_o,
  input  logic     push_ready_i
);

  logic [3:0] code;

  always_comb begin
    code                     = tok_i.data.link_word[15:12];
    push_data_o.is_literal   = tok_i.data.is_literal;
    push_data_o.literal_byte = tok_i.data.literal_byte;
    push_data_o.distance     = DIST_W'(tok_i.data.link_word[POS_W-1:0]) + DIST_W'(1);
    if (tok_i.data.is_literal) begin
      push_data_o.len = LEN_W'(1);
    end else if (code != 4'd0) begin
      push_data_o.len = LEN_W'(code) + LEN_W'(SHORT_BIAS);
    end else begin
      // zero code: length comes from the extra count byte
      push_data_o.len = LEN_W'(tok_i.data.count_extra) + LEN_W'(LONG_BIAS);
    end
  end

  assign push_valid_o = tok_i.valid;
  assign tok_i.ready  = push_ready_i;

endmodule

### hdl/yay0_queue.sv
// ----------------------------------------------------------------------------
// yay0_queue
// Short register FIFO of classified tokens between intake and copy engine.
// ----------------------------------------------------------------------------
module yay0_queue import yay0_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  tok_t push_data_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output tok_t pop_data_o,
  input  logic pop_ready_i
);

  tok_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              push, pop;

  always_comb begin
    push_ready_o = (count_q != (QPTR_W + 1)'(QDEPTH));
    pop_valid_o  = (count_q != '0);
    pop_data_o   = entry_q[rd_ptr_q];
    push         = push_valid_i && push_ready_o;
    pop          = pop_valid_o && pop_ready_i;
    wr_ptr_d     = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d     = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d      = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hdl/yay0_back.sv
// ----------------------------------------------------------------------------
// yay0_back
// Copy engine: unless stalled, issue one byte per cycle from the history ring,
// pack bytes into groups and hold a group in the output register until taken.
// ----------------------------------------------------------------------------
`include "yay0_lz_decompressor_defines.svh"

module yay0_back import yay0_pkg::*; #(
  parameter int unsigned OUT_LANES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] decoded_size_i,
  input  logic             pop_valid_i,
  input  tok_t             pop_data_i,
  output logic             pop_ready_o,
  yay0_grp_if.source       grp_o
);

  // issue stage
  logic             busy_q, busy_d;
  tok_t             tok_q, tok_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic [POS_W-1:0] wpos_q, wpos_d;
  logic [CNT_W-1:0] produced_q, produced_d, produced_inc;
  logic             finished_q, finished_d;
  logic             stall, a_issue, a_last, a_bad, a_done;
  logic [POS_W-1:0] rd_addr;

  // byte stage
  logic             b_valid_q, b_valid_d;
  logic             b_lit_q, b_fwd_q, b_bad_q, b_last_q, b_done_q;
  logic [POS_W-1:0] b_pos_q;
  logic [7:0]       b_lit_byte_q;
  logic [7:0]       ram_rdata, b_byte, last_byte_q;
  logic             b_fire;

  // group packing
  logic [7:0]       lane_q [OUT_LANES];
  logic [7:0]       lane_d [OUT_LANES];
  logic [7:0]       ob [8];
  logic [3:0]       fill_q, fill_d, fill_inc;
  logic             bad_acc_q, bad_acc_d, flush;
  grp_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;

  // -------- issue stage --------
  always_comb begin
    stall        = out_valid_q && !grp_o.ready;
    pop_ready_o  = !busy_q;
    a_issue      = busy_q && !stall;
    a_last       = (rem_q == LEN_W'(1));
    a_bad        = !tok_q.is_literal && (CNT_W'(tok_q.distance) > produced_q);
    produced_inc = (produced_q == CNT_MAX) ? produced_q : produced_q + 1'b1;
    a_done       = (produced_inc >= decoded_size_i);
    rd_addr      = wpos_q - tok_q.distance[POS_W-1:0];

    busy_d     = busy_q;
    tok_d      = tok_q;
    rem_d      = rem_q;
    wpos_d     = wpos_q;
    produced_d = produced_q;
    finished_d = finished_q;
    if (!busy_q) begin
      // drop tokens once the stream is complete
      if (pop_valid_i && !finished_q) begin
        busy_d = 1'b1;
        tok_d  = pop_data_i;
        rem_d  = pop_data_i.len;
      end
    end else if (a_issue) begin
      rem_d      = rem_q - 1'b1;
      wpos_d     = wpos_q + 1'b1;
      produced_d = produced_inc;
      if (a_last) begin
        busy_d     = 1'b0;
        finished_d = a_done;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      rem_q      <= '0;
      wpos_q     <= '0;
      produced_q <= '0;
      finished_q <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      rem_q      <= rem_d;
      wpos_q     <= wpos_d;
      produced_q <= produced_d;
      finished_q <= finished_d;
    end
  end

  yay0_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_SIZE)
  ) u_history (
    .clk_i  (clk_i),
    .we_i   (b_fire),
    .waddr_i(b_pos_q),
    .wdata_i(b_byte),
    .re_i   (a_issue && !tok_q.is_literal),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // -------- byte stage --------
  always_comb begin
    b_valid_d = stall ? b_valid_q : a_issue;
    b_fire    = b_valid_q && !stall;
    // distance one reads the byte written last cycle, so take it from the bypass
    if (b_lit_q) begin
      b_byte = b_lit_byte_q;
    end else if (b_bad_q) begin
      b_byte = 8'h00;
    end else if (b_fwd_q) begin
      b_byte = last_byte_q;
    end else begin
      b_byte = ram_rdata;
    end

    fill_inc = fill_q + 4'd1;
    for (int k = 0; k < OUT_LANES; k++) begin
      lane_d[k] = (b_fire && fill_q == 4'(k)) ? b_byte : lane_q[k];
    end
    flush = b_fire && ((fill_inc == 4'(OUT_LANES)) || b_last_q);

    for (int k = 0; k < 8; k++) begin
      ob[k] = 8'h00;
    end
    for (int k = 0; k < OUT_LANES; k++) begin
      if (4'(k) < fill_inc) begin
        ob[k] = lane_d[k];
      end
    end
    out_d.out_byte0     = ob[0];
    out_d.out_byte1     = ob[1];
    out_d.out_byte2     = ob[2];
    out_d.out_byte3     = ob[3];
    out_d.out_byte4     = ob[4];
    out_d.out_byte5     = ob[5];
    out_d.out_byte6     = ob[6];
    out_d.out_byte7     = ob[7];
    out_d.byte_count    = fill_inc;
    out_d.last_of_run   = b_last_q;
    out_d.stream_done   = b_done_q;
    out_d.bad_reference = bad_acc_q || b_bad_q;

    fill_d    = fill_q;
    bad_acc_d = bad_acc_q;
    if (b_fire) begin
      fill_d    = flush ? 4'd0 : fill_inc;
      bad_acc_d = flush ? 1'b0 : (bad_acc_q || b_bad_q);
    end

    if (flush) begin
      out_valid_d = 1'b1;
    end else if (grp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      fill_q      <= '0;
      bad_acc_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b_valid_q   <= b_valid_d;
      fill_q      <= fill_d;
      bad_acc_q   <= bad_acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (a_issue) begin
      b_lit_q      <= tok_q.is_literal;
      b_fwd_q      <= (tok_q.distance == DIST_W'(1));
      b_bad_q      <= a_bad;
      b_last_q     <= a_last;
      b_done_q     <= a_done;
      b_pos_q      <= wpos_q;
      b_lit_byte_q <= tok_q.literal_byte;
    end
    if (b_fire) begin
      last_byte_q <= b_byte;
    end
    for (int k = 0; k < OUT_LANES; k++) begin
      lane_q[k] <= lane_d[k];
    end
    if (flush) begin
      out_q <= out_d;
    end
  end

  assign grp_o.valid = out_valid_q;
  assign grp_o.data  = out_q;

  `YAY0_ASSERT_IMP(a_group_over_full, flush, !out_valid_q || grp_o.ready, "group loaded over untaken group")
  `YAY0_ASSERT_NXT(a_stall_hold, stall && b_valid_q, b_valid_q && $stable(b_pos_q), "byte stage moved in stall")
  `YAY0_ASSERT_NXT(a_run_end, a_issue && a_last, !busy_q, "run did not end on its last byte")
  `YAY0_ASSERT_IMP(a_done_idle, finished_q, !busy_q, "copy engine busy after stream end")
  `YAY0_ASSERT_IMP(a_fill_bound, b_valid_q, fill_q < 4'(OUT_LANES), "lane fill out of range")

endmodule

### hdl/yay0_lz_decompressor.sv
// ----------------------------------------------------------------------------
// yay0_lz_decompressor
// Yay0 LZ token decompressor: literal and back-reference tokens in, groups of
// up to OUT_LANES decoded bytes out, with a 4096-byte history ring.
// ----------------------------------------------------------------------------
//
//   channel  dir   payload                                       moves per request
//   tok_i    in    is_literal, literal_byte, link_word,           one token
//                  count_extra
//   grp_o    out   out_byte0..7, byte_count, last_of_run,         one byte group
//                  stream_done, bad_reference
//   cfg_i    in    decoded_size                                  one register write
//
// Copy: the copy engine reads the history through its single read port one
// byte a cycle while no group stalls it, and loads a new token only after the
// last byte of the one before. Tokens after the end of the stream are dropped.
// Reset: asynchronous, active low; clears counters, flags and the queue. The
// history RAM is not cleared and needs no clearing pass.
// Stalls: a group waiting in the output register holds the copy engine; the
// two-entry token queue keeps taking requests until it fills.
//
// ----------------------------------------------------------------------------
module yay0_lz_decompressor import yay0_pkg::*; #(
  parameter int unsigned OUT_LANES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  yay0_tok_if.sink    tok_i,
  yay0_cfg_if.sink    cfg_i,
  yay0_grp_if.source  grp_o
);

  logic [CNT_W-1:0] decoded_size_q;
  logic             push_valid, push_ready;
  tok_t             push_data;
  logic             pop_valid, pop_ready;
  tok_t             pop_data;

  // Always ready; user sends register writes only to an idle block; not enforced.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decoded_size_q <= '0;
    end else if (cfg_i.valid) begin
      decoded_size_q <= cfg_i.data.decoded_size;
    end
  end

  // Front: decode each token into byte, distance and run length.
  yay0_front u_front (
    .tok_i       (tok_i),
    .push_valid_o(push_valid),
    .push_data_o (push_data),
    .push_ready_i(push_ready)
  );

  // Queue: decouple token intake from the copy engine.
  yay0_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_data_i (push_data),
    .push_ready_o(push_ready),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data),
    .pop_ready_i (pop_ready)
  );

  // Back: copy bytes through the history and pack output groups.
  yay0_back #(
    .OUT_LANES(OUT_LANES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .decoded_size_i(decoded_size_q),
    .pop_valid_i   (pop_valid),
    .pop_data_i    (pop_data),
    .pop_ready_o   (pop_ready),
    .grp_o         (grp_o)
  );

endmodule

### sim/yay0_lz_decompressor_tb.sv
// ----------------------------------------------------------------------------
// yay0_lz_decompressor_tb
// Self-checking bench for the Yay0 token decompressor. A byte-exact model of
// the history ring predicts every byte group; random valid/ready gaps, a long
// output hold-off and several stream sizes exercise the handshakes and flags.
// ----------------------------------------------------------------------------
module yay0_lz_decompressor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import yay0_pkg::*;

  // Quiet time after the last group, long enough for the longest link to run.
  localparam int SETTLE_CYCLES = 300;
  // Length of the forced output stall.
  localparam int HOLD_CYCLES   = 400;

  logic clk;
  logic rst_n;

  yay0_tok_if tok_if ();
  yay0_cfg_if cfg_if ();
  yay0_grp_if grp_if ();

  yay0_lz_decompressor dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .tok_i  (tok_if),
    .cfg_i  (cfg_if),
    .grp_o  (grp_if)
  );

  // --------------------------------------------------------------------------
  // Group predictor: decodes each accepted token into the byte groups the
  // block must send, and compares arriving groups against them in order.
  // --------------------------------------------------------------------------
  class yay0_group_predictor;
    bit [7:0]       ring [WINDOW_SIZE];
    bit [POS_W-1:0] wr_pos;
    bit [CNT_W-1:0] produced;
    bit [CNT_W-1:0] size_limit;
    bit             finished;
    bit [7:0]       lane [8];
    int             fill;
    bit             fill_bad;
    grp_t           expected_groups [$];
    int             errors;
    int             tokens_decoded;
    int             tokens_ignored;
    int             groups_checked;
    int             bad_groups;

    function void set_size(bit [CNT_W-1:0] v);
      size_limit = v;
    endfunction

    function int pending();
      return expected_groups.size();
    endfunction

    function void close_group(bit last);
      grp_t g;
      g = '0;
      g.out_byte0     = lane[0];
      g.out_byte1     = lane[1];
      g.out_byte2     = lane[2];
      g.out_byte3     = lane[3];
      g.out_byte4     = lane[4];
      g.out_byte5     = lane[5];
      g.out_byte6     = lane[6];
      g.out_byte7     = lane[7];
      g.byte_count    = 4'(fill);
      g.last_of_run   = last;
      g.stream_done   = (produced >= size_limit);
      g.bad_reference = fill_bad;
      expected_groups.push_back(g);
      foreach (lane[k]) lane[k] = 8'h00;
      fill     = 0;
      fill_bad = 1'b0;
    endfunction

    function void emit_byte(bit [7:0] b, bit bad, bit last);
      ring[wr_pos] = b;
      wr_pos++;
      if (produced != CNT_MAX) produced++;
      lane[fill] = b;
      fill++;
      if (bad) fill_bad = 1'b1;
      if (fill == 8 || last) close_group(last);
    endfunction

    function void decode_token(tok_in_t t);
      int unsigned    len;
      int unsigned    distance;
      bit [3:0]       code;
      bit [POS_W-1:0] src;
      bit             bad;
      if (finished) begin
        tokens_ignored++;
        return;
      end
      tokens_decoded++;
      if (t.is_literal) begin
        emit_byte(t.literal_byte, 1'b0, 1'b1);
      end else begin
        distance = int'(t.link_word[11:0]) + 1;
        code     = t.link_word[15:12];
        len      = (code != 4'h0) ? int'(code) + SHORT_BIAS : int'(t.count_extra) + LONG_BIAS;
        for (int unsigned i = 0; i < len; i++) begin
          bad = distance > produced;
          src = wr_pos - POS_W'(distance);
          emit_byte(bad ? 8'h00 : ring[src], bad, i == len - 1);
        end
      end
      if (produced >= size_limit) finished = 1'b1;
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_group(grp_t got);
      grp_t want;
      if (expected_groups.size() == 0) begin
        $error("byte group with no token behind it, byte_count %0d", got.byte_count);
        errors++;
        return;
      end
      want = expected_groups.pop_front();
      groups_checked++;
      if (want.bad_reference) bad_groups++;
      compare("out_byte0", want.out_byte0, got.out_byte0);
      compare("out_byte1", want.out_byte1, got.out_byte1);
      compare("out_byte2", want.out_byte2, got.out_byte2);
      compare("out_byte3", want.out_byte3, got.out_byte3);
      compare("out_byte4", want.out_byte4, got.out_byte4);
      compare("out_byte5", want.out_byte5, got.out_byte5);
      compare("out_byte6", want.out_byte6, got.out_byte6);
      compare("out_byte7", want.out_byte7, got.out_byte7);
      compare("byte_count", 8'(want.byte_count), 8'(got.byte_count));
      compare("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
      compare("stream_done", 8'(want.stream_done), 8'(got.stream_done));
      compare("bad_reference", 8'(want.bad_reference), 8'(got.bad_reference));
    endfunction
  endclass

  yay0_group_predictor grp_pred = new;

  // Per-cycle idle odds of each side, in percent; set by the main sequence.
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  // Raise to make the receiver hold off for HOLD_CYCLES.
  bit hold_request = 1'b0;

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run; a correct one needs well under a tenth of this.
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: check every accepted group, then pick ready for the next cycle.
  // The long hold-off is counted here so the sender keeps pushing meanwhile.
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    grp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && grp_if.valid && grp_if.ready) grp_pred.check_group(grp_if.data);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        grp_if.ready <= 1'b0;
      end else begin
        grp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Token builders. Fields a token does not use get random junk so that
  // every input bit toggles.
  // --------------------------------------------------------------------------
  function automatic tok_in_t lit_tok(bit [7:0] b);
    tok_in_t t;
    t.is_literal   = 1'b1;
    t.literal_byte = b;
    t.link_word    = 16'($urandom);
    t.count_extra  = 8'($urandom);
    return t;
  endfunction

  // Build a link from its distance (1..4096), length code and count byte.
  function automatic tok_in_t link_tok(int unsigned distance, bit [3:0] code, bit [7:0] extra);
    tok_in_t t;
    t.is_literal   = 1'b0;
    t.literal_byte = 8'($urandom);
    t.link_word    = {code, 12'(distance - 1)};
    t.count_extra  = extra;
    return t;
  endfunction

  // Mostly well-formed links that reach back into written history; one in
  // ten draws any distance, which may point before the stream start.
  function automatic tok_in_t rand_token();
    int unsigned pick;
    int unsigned reach;
    bit [3:0]    code;
    pick = $urandom_range(99);
    if (pick < 35) return lit_tok(8'($urandom));
    reach = (grp_pred.produced > WINDOW_SIZE) ? WINDOW_SIZE : int'(grp_pred.produced);
    code  = (pick < 60) ? 4'($urandom_range(15, 1)) : 4'h0;
    if (reach == 0 || $urandom_range(9) == 0)
      return link_tok($urandom_range(WINDOW_SIZE, 1), code, 8'($urandom));
    return link_tok($urandom_range(reach, 1), code, 8'($urandom));
  endfunction

  // --------------------------------------------------------------------------
  // Driver tasks. Each starts and ends on a clock edge. push_token leaves
  // valid high so back-to-back requests need no second assignment per edge.
  // --------------------------------------------------------------------------
  task automatic push_token(tok_in_t t);
    while ($urandom_range(99) < snd_idle_pct) begin
      tok_if.valid <= 1'b0;
      @(posedge clk);
    end
    tok_if.valid <= 1'b1;
    tok_if.data  <= t;
    do @(posedge clk); while (!tok_if.ready);
    grp_pred.decode_token(t);
  endtask

  task automatic push_random(int n);
    repeat (n) push_token(rand_token());
  endtask

  // Drop valid, let every predicted group drain, then give any token that
  // yields nothing time to clear the engine.
  task automatic wait_idle();
    tok_if.valid <= 1'b0;
    while (grp_pred.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write decoded_size; only called with the block idle.
  task automatic write_size(bit [CNT_W-1:0] v);
    cfg_if.valid                   <= 1'b1;
    cfg_if.data.decoded_size <= v;
    do @(posedge clk); while (!cfg_if.ready);
    grp_pred.set_size(v);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    tok_if.valid <= 1'b0;
    tok_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Largest size first, so the stream stays open through the bulk of the run.
    write_size(CNT_MAX);
    snd_idle_pct = 38;
    rcv_idle_pct = 55;

    // Directed tokens. Reference before the stream start: every byte reads 0.
    push_token(link_tok(1, 4'h1, 8'h00));
    push_token(lit_tok(8'h00));
    push_token(lit_tok(8'hff));
    push_token(lit_tok(8'ha5));
    push_token(lit_tok(8'h5a));
    // Half the run reaches before the start, half reads the first two bytes.
    push_token(link_tok(grp_pred.produced + 2, 4'h2, 8'hff));
    // Overlapping copy at distance one replicates the last byte, 17 long.
    push_token(link_tok(1, 4'hf, 8'h00));
    // Exactly one full group.
    push_token(link_tok(2, 4'h6, 8'h55));
    // Long form with the smallest and largest count byte.
    push_token(link_tok(4, 4'h0, 8'h00));
    push_token(link_tok(3, 4'h0, 8'hff));
    // All-ones and all-zero link words.
    push_token(link_tok(WINDOW_SIZE, 4'hf, 8'h00));
    push_token(link_tok(1, 4'h0, 8'h00));
    push_token(link_tok(7, 4'h0, 8'hff));
    push_token(link_tok(100, 4'h0, 8'hc8));
    push_token(link_tok(50, 4'h0, 8'hff));
    push_token(lit_tok(8'($urandom)));
    push_token(lit_tok(8'($urandom)));

    push_random(25);

    // Hold the output off while tokens keep coming, so the queue fills and
    // the input stalls.
    hold_request = 1'b1;
    push_random(6);
    wait_idle();

    // Mid-range size, still far above what the run produces.
    write_size(CNT_W'($urandom_range(CNT_MAX - 1, 24'h010000)));
    snd_idle_pct = 55;
    rcv_idle_pct = 38;
    push_random(25);
    // Pause the sender until every group is back.
    wait_idle();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    push_random(20);
    wait_idle();

    // Size zero: the next token still decodes in full, every group flags
    // done, and the stream ends.
    write_size('0);
    push_token(link_tok(WINDOW_SIZE, 4'h0, 8'hff));
    // Tokens after the end are dropped.
    push_random(8);
    wait_idle();
    // A new size does not reopen a finished stream.
    write_size(CNT_MAX);
    push_random(4);
    wait_idle();

    $display("Decoded %0d tokens, dropped %0d after the end of the stream",
             grp_pred.tokens_decoded, grp_pred.tokens_ignored);
    $display("Checked %0d byte groups, %0d reaching before the stream start",
             grp_pred.groups_checked, grp_pred.bad_groups);
    if (grp_pred.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### yay0_lz_decompressor.f
+incdir+hdl
hdl/yay0_pkg.sv
hdl/yay0_ifs.sv
hdl/yay0_ram.sv
hdl/yay0_front.sv
hdl/yay0_queue.sv
hdl/yay0_back.sv
hdl/yay0_lz_decompressor.sv
sim/yay0_lz_decompressor_tb.sv
